[src/slec_pkg.sv]
// Shared types and constants for the stimulus-locked epoch capture block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package slec_pkg;

    // widths sized for the largest legal module parameters
    localparam int CH_W   = 6;   // channel index, up to 64 channels
    localparam int CC_W   = 7;   // channel count 1..64
    localparam int WL_W   = 11;  // window length 1..1024
    localparam int TC_W   = 7;   // target count 1..64
    localparam int EP_W   = 11;  // epoch slot count 1..1024
    localparam int LIM_W  = 17;  // entries per epoch, up to 65536
    localparam int FILL_W = 11;  // per-epoch fill counter
    localparam int CHK_W  = 15;  // epochs_per_target * (target + 1)

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_NEW    = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_CHANNEL_COUNT     = 3'd0,
        REG_WINDOW_LENGTH     = 3'd1,
        REG_EPOCHS_PER_TARGET = 3'd2,
        REG_TARGET_COUNT      = 3'd3,
        REG_ROW_COL_MODE      = 3'd4,
        REG_GRID_ROWS         = 3'd5
    } t_reg_idx;

    // configuration after clamping
    typedef struct packed {
        logic [CC_W-1:0]  cc;
        logic [WL_W-1:0]  wl;
        logic [7:0]       ept;
        logic [TC_W-1:0]  tc;
        logic [EP_W-1:0]  total;
        logic [LIM_W-1:0] limit;
        logic             row_col;
        logic [4:0]       rows;
    } t_cfg;

    typedef struct packed {
        t_action           action;
        logic signed [23:0] sample;
        logic [7:0]        stim;
        logic [6:0]        slot;
        logic [7:0]        tid;
        logic [9:0]        pos;
        logic [CH_W-1:0]   ch;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic              target_done;
        logic              session_done;
        logic signed [23:0] read_sample;
        logic [7:0]        read_stimulus;
        logic              read_label;
        logic              error;
    } t_result;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              open;
        logic [7:0]        stim;
        logic              label;
    } t_epoch;

endpackage

`default_nettype wire

[src/slec_fifo.sv]
// Two-entry queue used between front and back and on the result side.
// No dependencies.
`default_nettype none

module slec_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/slec_front.sv]
// Front end: takes input beats, tracks the channel position inside a frame
// and hands classified commands to the queue. Uses slec_pkg.
`default_nettype none

module slec_front #(
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [23:0] i_sample,
    input  wire logic [7:0]         i_stimulus_code,
    input  wire logic [6:0]         i_slot_index,
    input  wire logic [7:0]         i_target_id,
    input  wire logic [9:0]         i_entry_position,
    input  wire slec_pkg::t_cfg     i_cfg,
    output slec_pkg::t_cmd          o_cmd,
    output logic                    o_cmd_push,
    input  wire logic               i_cmd_full
);

    localparam int CNT_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic             r_stg_valid;
    slec_pkg::t_cmd   r_stg;
    logic [CNT_W-1:0] r_chan;
    logic [CNT_W-1:0] ch;
    logic             last;
    logic             drain;
    logic             accept;

    assign drain  = r_stg_valid && !i_cmd_full;
    assign o_full = r_stg_valid && i_cmd_full;
    assign accept = i_push && !o_full;

    // a counter past channel_count counts as the frame's last channel
    always_comb begin
        if (slec_pkg::CC_W'(r_chan) < i_cfg.cc) begin
            ch = r_chan;
        end else begin
            ch = CNT_W'(i_cfg.cc - slec_pkg::CC_W'(1));
        end
        last = (slec_pkg::CC_W'(ch) == i_cfg.cc - slec_pkg::CC_W'(1));
    end

    always_comb begin
        o_cmd      = r_stg;
        o_cmd.ch   = slec_pkg::CH_W'(ch);
        o_cmd.last = last;
        o_cmd_push = r_stg_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_chan      <= '0;
        end else begin
            if (accept) begin
                r_stg_valid <= 1'b1;
            end else if (drain) begin
                r_stg_valid <= 1'b0;
            end
            if (drain) begin
                if (r_stg.action == slec_pkg::ACT_NEW) begin
                    r_chan <= '0;
                end else if (r_stg.action == slec_pkg::ACT_SAMPLE) begin
                    r_chan <= last ? '0 : ch + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg.action <= slec_pkg::t_action'(i_action);
            r_stg.sample <= i_sample;
            r_stg.stim   <= i_stimulus_code;
            r_stg.slot   <= i_slot_index;
            r_stg.tid    <= i_target_id;
            r_stg.pos    <= i_entry_position;
            r_stg.ch     <= '0;
            r_stg.last   <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[src/slec_div.sv]
// Restoring divider for the row/column label: 8-bit target id by grid rows,
// one quotient bit per cycle. No dependencies.
`default_nettype none

module slec_div (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [7:0] i_dividend,
    input  wire logic [4:0] i_divisor,
    output logic            o_busy,
    output logic [7:0]      o_quot,
    output logic [4:0]      o_rem
);

    logic       r_busy;
    logic [2:0] r_cnt;
    logic [5:0] r_rem;
    logic [7:0] r_quo;
    logic [4:0] r_div;
    logic [5:0] trial;
    logic       fits;

    assign trial  = {r_rem[4:0], r_quo[7]};
    assign fits   = (trial >= {1'b0, r_div});
    assign o_busy = r_busy;
    assign o_quot = r_quo;
    assign o_rem  = r_rem[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? trial - {1'b0, r_div} : trial;
            r_quo <= {r_quo[6:0], fits};
        end
    end

endmodule

`default_nettype wire

[src/slec_back.sv]
// Back end: epoch bookkeeping, sample store, target table and completion
// checks. Uses slec_pkg and slec_div.
`default_nettype none

module slec_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WINDOW   = 128,
    parameter int MAX_EPOCHS   = 128,
    parameter int MAX_TARGETS  = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire slec_pkg::t_cfg  i_cfg,
    input  wire slec_pkg::t_cmd  i_cmd,
    input  wire logic            i_cmd_empty,
    output logic                 o_cmd_pop,
    output slec_pkg::t_result    o_res,
    output logic                 o_res_push,
    input  wire logic            i_res_full
);

    localparam int EE    = MAX_CHANNELS * MAX_WINDOW;
    localparam int SD    = MAX_EPOCHS * EE;
    localparam int EPI_W = (MAX_EPOCHS > 1) ? $clog2(MAX_EPOCHS) : 1;
    localparam int TGI_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int SA_W  = (SD > 1) ? $clog2(SD) : 1;
    localparam int P_W   = slec_pkg::LIM_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_LABEL, S_DIV, S_WALK, S_READ, S_FIN, S_OUT
    } t_state;

    t_state               r_state;
    slec_pkg::t_cmd       r_cmd;
    slec_pkg::t_result    r_res;
    logic [TGI_W-1:0]     r_cur;
    logic [TGI_W-1:0]     r_curc;
    logic [slec_pkg::CHK_W-1:0] r_chk_raw;
    logic                 r_alloc;
    logic                 r_found;
    logic                 r_lbl;
    logic                 r_chk_full;
    logic                 r_tot_full;
    logic [EPI_W:0]       r_widx;
    logic [EPI_W-1:0]     r_pidx;
    logic                 r_pv;
    logic [MAX_EPOCHS-1:0] r_epoch_vld;

    // storage
    logic signed [23:0]   r_sample_mem [SD];
    slec_pkg::t_epoch     r_epoch_mem [MAX_EPOCHS];
    logic [7:0]           r_target_tab [MAX_TARGETS];
    logic signed [23:0]   r_rd_sample;
    slec_pkg::t_epoch     r_ep_q;
    logic                 r_ep_qv;
    logic [7:0]           r_tgt_val;

    logic [TGI_W-1:0]     cur_c;
    logic [EPI_W-1:0]     ep_raddr;
    logic [SA_W-1:0]      rd_addr;
    logic [SA_W-1:0]      wr_addr;
    logic                 smp_we;
    logic                 ep_we;
    slec_pkg::t_epoch     ep;
    slec_pkg::t_epoch     ep_new;
    logic                 open_new;
    logic                 eff_open;
    logic [P_W-1:0]       p;
    logic [slec_pkg::CHK_W-1:0] chk_m1;
    logic [slec_pkg::CHK_W-1:0] tot_m1;
    logic [slec_pkg::CHK_W-1:0] chk;
    logic                 is_full;
    logic                 div_start;
    logic                 div_busy;
    logic [7:0]           div_q;
    logic [4:0]           div_r;
    logic [8:0]           row_code;
    logic [5:0]           col_code;
    logic                 rc_lbl;

    slec_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tgt_val),
        .i_divisor  (i_cfg.rows),
        .o_busy     (div_busy),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    assign div_start  = (r_state == S_LABEL) && r_alloc && i_cfg.row_col;
    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_res      = r_res;

    // row = ceil(t / rows), column = (t mod rows) + rows, wrapping to 2*rows
    always_comb begin
        row_code = {1'b0, div_q} + {8'd0, (div_r != 5'd0)};
        col_code = (div_r == 5'd0) ? {i_cfg.rows, 1'b0} : {1'b0, div_r} + {1'b0, i_cfg.rows};
        rc_lbl   = ({1'b0, r_cmd.stim} == row_code) || (r_cmd.stim == {2'b00, col_code});
    end

    always_comb begin
        if (slec_pkg::TC_W'(r_cur) < i_cfg.tc) begin
            cur_c = r_cur;
        end else begin
            cur_c = TGI_W'(i_cfg.tc - slec_pkg::TC_W'(1));
        end
        chk_m1 = r_chk_raw - slec_pkg::CHK_W'(1);
        tot_m1 = slec_pkg::CHK_W'(i_cfg.total) - slec_pkg::CHK_W'(1);
        chk    = (chk_m1 > tot_m1) ? tot_m1 : chk_m1;
    end

    // one epoch slot per cycle during the walk
    always_comb begin
        ep       = r_ep_qv ? r_ep_q : '0;
        open_new = r_alloc && !r_found
                   && (slec_pkg::EP_W'(r_pidx) < i_cfg.total)
                   && (ep.fill == '0) && !ep.open;
        eff_open = ep.open || open_new;
        p        = P_W'(ep.fill) + P_W'(r_cmd.ch);
        ep_new   = ep;
        if (open_new) begin
            ep_new.stim  = r_cmd.stim;
            ep_new.label = r_lbl;
        end
        ep_new.open = eff_open;
        if (eff_open && r_cmd.last) begin
            ep_new.fill = ep.fill + slec_pkg::FILL_W'(i_cfg.cc);
            if (slec_pkg::LIM_W'(ep_new.fill) >= i_cfg.limit) begin
                ep_new.open = 1'b0;
            end
        end
        is_full  = (slec_pkg::LIM_W'(ep_new.fill) >= i_cfg.limit);
        ep_we    = (r_state == S_WALK) && r_pv && eff_open;
        smp_we   = ep_we && (p < P_W'(EE));
        wr_addr  = SA_W'(SA_W'(r_pidx) * SA_W'(EE) + SA_W'(p));
        rd_addr  = SA_W'(SA_W'(r_cmd.slot) * SA_W'(EE) + SA_W'(r_cmd.pos));
        ep_raddr = (r_state == S_WALK) ? r_widx[EPI_W-1:0] : EPI_W'(r_cmd.slot);
    end

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            r_sample_mem[wr_addr] <= r_cmd.sample;
        end
        r_rd_sample <= r_sample_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ep_we) begin
            r_epoch_mem[r_pidx] <= ep_new;
        end
        r_ep_q  <= r_epoch_mem[ep_raddr];
        r_ep_qv <= r_epoch_vld[ep_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PREP && r_cmd.action == slec_pkg::ACT_LOAD
            && 7'(r_cmd.slot) < 7'(MAX_TARGETS)) begin
            r_target_tab[TGI_W'(r_cmd.slot)] <= r_cmd.tid;
        end
        r_tgt_val <= r_target_tab[cur_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_pv        <= 1'b0;
            r_epoch_vld <= '0;
        end else begin
            if (ep_we) begin
                r_epoch_vld[r_pidx] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_res      <= '0;
                    r_curc     <= cur_c;
                    r_chk_raw  <= slec_pkg::CHK_W'(i_cfg.ept)
                                  * slec_pkg::CHK_W'(slec_pkg::TC_W'(cur_c) + slec_pkg::TC_W'(1));
                    r_alloc    <= (r_cmd.ch == '0) && (r_cmd.stim != 8'd0);
                    r_found    <= 1'b0;
                    r_chk_full <= 1'b0;
                    r_tot_full <= 1'b0;
                    unique case (r_cmd.action)
                        slec_pkg::ACT_SAMPLE: r_state <= S_LABEL;
                        slec_pkg::ACT_LOAD:   r_state <= S_OUT;
                        slec_pkg::ACT_NEW: begin
                            r_epoch_vld <= '0;
                            r_cur       <= '0;
                            r_state     <= S_OUT;
                        end
                        slec_pkg::ACT_READ:   r_state <= S_READ;
                        default:              r_state <= S_OUT;
                    endcase
                end
                S_LABEL: begin
                    r_lbl  <= (r_cmd.stim == r_tgt_val);
                    r_widx <= '0;
                    r_pv   <= 1'b0;
                    if (r_alloc && i_cfg.row_col) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_DIV: begin
                    if (!div_busy) begin
                        r_lbl   <= rc_lbl;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_widx < (EPI_W+1)'(MAX_EPOCHS)) begin
                        r_pidx <= r_widx[EPI_W-1:0];
                        r_pv   <= 1'b1;
                        r_widx <= r_widx + (EPI_W+1)'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        if (open_new) begin
                            r_found <= 1'b1;
                        end
                        if (slec_pkg::CHK_W'(r_pidx) == chk) begin
                            r_chk_full <= is_full;
                        end
                        if (slec_pkg::CHK_W'(r_pidx) == tot_m1) begin
                            r_tot_full <= is_full;
                        end
                        if (r_widx == (EPI_W+1)'(MAX_EPOCHS)) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res.error <= r_alloc && !r_found;
                    if (r_cmd.last) begin
                        r_res.target_done  <= r_chk_full;
                        r_res.session_done <= r_tot_full;
                        if (r_chk_full) begin
                            if (slec_pkg::TC_W'(r_curc) < i_cfg.tc - slec_pkg::TC_W'(1)) begin
                                r_cur <= r_curc + TGI_W'(1);
                            end else begin
                                r_cur <= TGI_W'(i_cfg.tc - slec_pkg::TC_W'(1));
                            end
                        end
                    end
                    r_state <= S_OUT;
                end
                S_READ: begin
                    if (11'(r_cmd.slot) < 11'(MAX_EPOCHS)) begin
                        if (P_W'(r_cmd.pos) < P_W'(EE)) begin
                            r_res.read_sample <= r_rd_sample;
                        end
                        if (r_ep_qv) begin
                            r_res.read_stimulus <= r_ep_q.stim;
                            r_res.read_label    <= r_ep_q.label;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/stimulus_locked_epoch_capture.sv]
// Top level of the stimulus-locked epoch capture block: configuration
// registers, front end, command and result queues, back end. Uses slec_pkg.
//
// Samples arrive one channel per beat; a nonzero stimulus code on channel 0
// opens the lowest free epoch slot, and every open epoch stores each sample
// until window_length * channel_count entries are held. One result beat comes
// back per input beat. For a sample beat the back end walks all epoch slots,
// one slot per cycle through the epoch table's single read port; a row/column
// beat with a stimulus code on channel 0 first waits for the label divider.
// Load, new-session and read beats skip the walk. The front end and a
// two-beat queue take the next beat while the back end is busy, and a
// two-beat result queue decouples the consumer. Configuration takes effect
// through a clamped, registered copy; it is to be changed only while the
// block is idle, a rule for the user that the block does not enforce.
`default_nettype none

module stimulus_locked_epoch_capture #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WINDOW   = 128,
    parameter int MAX_EPOCHS   = 128,
    parameter int MAX_TARGETS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [23:0] i_sample,
    input  wire logic [7:0]         i_stimulus_code,
    input  wire logic [6:0]         i_slot_index,
    input  wire logic [7:0]         i_target_id,
    input  wire logic [9:0]         i_entry_position,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_target_done,
    output logic                    o_session_done,
    output logic signed [23:0]      o_read_sample,
    output logic [7:0]              o_read_stimulus,
    output logic                    o_read_label,
    output logic                    o_error
);

    logic [3:0] r_channel_count;
    logic [7:0] r_window_length;
    logic [7:0] r_epochs_per_target;
    logic [4:0] r_target_count;
    logic       r_row_col_mode;
    logic [4:0] r_grid_rows;

    slec_pkg::t_cfg    r_cfg;
    slec_pkg::t_cfg    n_cfg;
    slec_pkg::t_cmd    front_cmd;
    slec_pkg::t_cmd    cmd_head;
    slec_pkg::t_result back_res;
    slec_pkg::t_result res_head;
    logic              cmd_push;
    logic              cmd_full;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              res_push;
    logic              res_full;
    logic [14:0]       total_prod;
    logic [17:0]       limit_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count     <= 4'd8;
            r_window_length     <= 8'd128;
            r_epochs_per_target <= 8'd12;
            r_target_count      <= 5'd1;
            r_row_col_mode      <= 1'b0;
            r_grid_rows         <= 5'd6;
        end else if (i_cfg_we) begin
            unique case (slec_pkg::t_reg_idx'(i_cfg_idx))
                slec_pkg::REG_CHANNEL_COUNT:     r_channel_count     <= i_cfg_data[3:0];
                slec_pkg::REG_WINDOW_LENGTH:     r_window_length     <= i_cfg_data;
                slec_pkg::REG_EPOCHS_PER_TARGET: r_epochs_per_target <= i_cfg_data;
                slec_pkg::REG_TARGET_COUNT:      r_target_count      <= i_cfg_data[4:0];
                slec_pkg::REG_ROW_COL_MODE:      r_row_col_mode      <= i_cfg_data[0];
                slec_pkg::REG_GRID_ROWS:         r_grid_rows         <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp registers into their legal ranges
    always_comb begin
        n_cfg = '0;
        if (r_channel_count == 4'd0) begin
            n_cfg.cc = slec_pkg::CC_W'(1);
        end else if (slec_pkg::CC_W'(r_channel_count) > slec_pkg::CC_W'(MAX_CHANNELS)) begin
            n_cfg.cc = slec_pkg::CC_W'(MAX_CHANNELS);
        end else begin
            n_cfg.cc = slec_pkg::CC_W'(r_channel_count);
        end
        if (r_window_length == 8'd0) begin
            n_cfg.wl = slec_pkg::WL_W'(1);
        end else if (slec_pkg::WL_W'(r_window_length) > slec_pkg::WL_W'(MAX_WINDOW)) begin
            n_cfg.wl = slec_pkg::WL_W'(MAX_WINDOW);
        end else begin
            n_cfg.wl = slec_pkg::WL_W'(r_window_length);
        end
        if (r_epochs_per_target == 8'd0) begin
            n_cfg.ept = 8'd1;
        end else if (r_epochs_per_target > 8'd128) begin
            n_cfg.ept = 8'd128;
        end else begin
            n_cfg.ept = r_epochs_per_target;
        end
        if (r_target_count == 5'd0) begin
            n_cfg.tc = slec_pkg::TC_W'(1);
        end else if (slec_pkg::TC_W'(r_target_count) > slec_pkg::TC_W'(MAX_TARGETS)) begin
            n_cfg.tc = slec_pkg::TC_W'(MAX_TARGETS);
        end else begin
            n_cfg.tc = slec_pkg::TC_W'(r_target_count);
        end
        total_prod = 15'(n_cfg.ept) * 15'(n_cfg.tc);
        limit_prod = 18'(n_cfg.wl) * 18'(n_cfg.cc);
        if (total_prod > 15'(MAX_EPOCHS)) begin
            n_cfg.total = slec_pkg::EP_W'(MAX_EPOCHS);
        end else begin
            n_cfg.total = slec_pkg::EP_W'(total_prod);
        end
        n_cfg.limit   = slec_pkg::LIM_W'(limit_prod);
        n_cfg.row_col = r_row_col_mode;
        n_cfg.rows    = (r_grid_rows == 5'd0) ? 5'd1 : r_grid_rows;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    slec_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_action         (i_action),
        .i_sample         (i_sample),
        .i_stimulus_code  (i_stimulus_code),
        .i_slot_index     (i_slot_index),
        .i_target_id      (i_target_id),
        .i_entry_position (i_entry_position),
        .i_cfg            (r_cfg),
        .o_cmd            (front_cmd),
        .o_cmd_push       (cmd_push),
        .i_cmd_full       (cmd_full)
    );

    slec_fifo #(
        .W ($bits(slec_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_empty (cmd_empty)
    );

    slec_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_EPOCHS   (MAX_EPOCHS),
        .MAX_TARGETS  (MAX_TARGETS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd_head),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    slec_fifo #(
        .W ($bits(slec_pkg::t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_target_done   = res_head.target_done;
    assign o_session_done  = res_head.session_done;
    assign o_read_sample   = res_head.read_sample;
    assign o_read_stimulus = res_head.read_stimulus;
    assign o_read_label    = res_head.read_label;
    assign o_error         = res_head.error;

    // back end never pushes a result beat into a full queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result beat pushed while result queue full");

    // back end takes a command only when one is waiting
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // no result survives a reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

`default_nettype wire

[test/stimulus_locked_epoch_capture_tb.sv]
// Testbench for stimulus_locked_epoch_capture: directed and random beats
// checked against a behavioral predictor of epoch capture. Needs slec_pkg.
`timescale 1ns / 1ps

module stimulus_locked_epoch_capture_tb;

    localparam int ENTRIES    = 1024;
    localparam int SLOTS      = 128;
    localparam int TARGETS    = 16;
    localparam int STALL_LIMIT = 6000;

    typedef struct {
        slec_pkg::t_action action;
        logic [23:0] sample;
        logic [7:0] stim;
        logic [6:0] slot;
        logic [7:0] tid;
        logic [9:0] pos;
    } t_beat;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        push = 0;
    logic        full;
    logic [1:0]  i_action = '0;
    logic signed [23:0] i_sample = '0;
    logic [7:0]  i_stimulus_code = '0;
    logic [6:0]  i_slot_index = '0;
    logic [7:0]  i_target_id = '0;
    logic [9:0]  i_entry_position = '0;
    logic        empty;
    logic        pop = 0;
    logic        o_target_done, o_session_done, o_read_label, o_error;
    logic signed [23:0] o_read_sample;
    logic [7:0]  o_read_stimulus;

    stimulus_locked_epoch_capture u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_action(i_action), .i_sample(i_sample), .i_stimulus_code(i_stimulus_code),
        .i_slot_index(i_slot_index), .i_target_id(i_target_id),
        .i_entry_position(i_entry_position),
        .empty(empty), .pop(pop),
        .o_target_done(o_target_done), .o_session_done(o_session_done),
        .o_read_sample(o_read_sample), .o_read_stimulus(o_read_stimulus),
        .o_read_label(o_read_label), .o_error(o_error)
    );

    initial forever #5 i_clk = ~i_clk;

    // predictor state
    int          reg_cc = 8, reg_wl = 128, reg_ept = 12, reg_tc = 1, reg_rc = 0, reg_rows = 6;
    logic [23:0] capture_mem [0:SLOTS*ENTRIES-1];
    bit          mem_written [0:SLOTS*ENTRIES-1];
    int          written_addrs [$];
    int          fill [SLOTS];
    bit          open_q [SLOTS];
    logic [7:0]  ep_stim [SLOTS];
    bit          ep_label [SLOTS];
    logic [7:0]  tgt_table [TARGETS];
    int          cur_tgt, started, chan;

    slec_pkg::t_result pending_results [$];
    int          errors = 0;
    int          beats_sent = 0;
    bit          quiet = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;
    int          stall_cycles = 0;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void clear_session();
        for (int i = 0; i < SLOTS; i++) begin
            fill[i] = 0; open_q[i] = 0; ep_stim[i] = 0; ep_label[i] = 0;
        end
        cur_tgt = 0; started = 0; chan = 0;
    endfunction

    function automatic int row_of(int t, int rows);
        return (t + rows - 1) / rows;
    endfunction

    function automatic int col_of(int t, int rows);
        int c;
        c = (t % rows) + rows;
        if (c == rows) c += rows;
        return c;
    endfunction

    function automatic bit label_of(int stim, int cur);
        int t, rows;
        t = tgt_table[cur];
        if (!reg_rc) return stim == t;
        rows = reg_rows ? reg_rows : 1;
        return stim == row_of(t, rows) || stim == col_of(t, rows);
    endfunction

    function automatic slec_pkg::t_result predict_epochs(t_beat b);
        slec_pkg::t_result r;
        int cc, wl, ept, tc, total, cur, ch, lim, chk, addr;
        bit found;
        r = '0;
        case (b.action)
            slec_pkg::ACT_LOAD: if (b.slot < TARGETS) tgt_table[b.slot] = b.tid;
            slec_pkg::ACT_NEW:  clear_session();
            slec_pkg::ACT_READ: begin
                r.read_sample   = capture_mem[b.slot * ENTRIES + b.pos];
                r.read_stimulus = ep_stim[b.slot];
                r.read_label    = ep_label[b.slot];
            end
            default: begin
                cc = clampi(reg_cc, 1, 8); wl = clampi(reg_wl, 1, 128);
                ept = clampi(reg_ept, 1, 128); tc = clampi(reg_tc, 1, 16);
                total = ept * tc;
                if (total > SLOTS) total = SLOTS;
                cur = cur_tgt < tc ? cur_tgt : tc - 1;
                ch = chan < cc ? chan : cc - 1;
                if (ch == 0 && b.stim != 0) begin
                    found = 0;
                    for (int i = 0; i < total && !found; i++) begin
                        if (fill[i] == 0 && !open_q[i]) begin
                            open_q[i] = 1; ep_stim[i] = b.stim;
                            ep_label[i] = label_of(b.stim, cur);
                            if (started < 255) started++;
                            found = 1;
                        end
                    end
                    if (!found) r.error = 1;
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (open_q[i] && fill[i] + ch < ENTRIES) begin
                        addr = i * ENTRIES + fill[i] + ch;
                        capture_mem[addr] = b.sample;
                        if (!mem_written[addr]) begin
                            mem_written[addr] = 1;
                            written_addrs.insert(written_addrs.size(), addr);
                        end
                    end
                end
                if (ch == cc - 1) begin
                    lim = wl * cc;
                    chan = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (open_q[i]) begin
                            fill[i] = (fill[i] + cc) & 11'h7FF;
                            if (fill[i] >= lim) open_q[i] = 0;
                        end
                    end
                    chk = ept * (cur + 1) - 1;
                    if (chk > total - 1) chk = total - 1;
                    if (fill[chk] >= lim) begin
                        r.target_done = 1;
                        cur_tgt = cur < tc - 1 ? cur + 1 : tc - 1;
                    end
                    if (fill[total - 1] >= lim) r.session_done = 1;
                end else begin
                    chan = (ch + 1) & 7;
                end
            end
        endcase
        return r;
    endfunction

    // ---------------- sender side ----------------
    task automatic send_beat(t_beat b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            push = 0;
            repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push = 1;
        i_action = b.action; i_sample = b.sample; i_stimulus_code = b.stim;
        i_slot_index = b.slot; i_target_id = b.tid; i_entry_position = b.pos;
        do @(posedge i_clk); while (full);
        pending_results.insert(pending_results.size(), predict_epochs(b));
        beats_sent++;
    endtask

    function automatic t_beat rand_beat(slec_pkg::t_action act);
        t_beat b;
        b.action = act; b.sample = 24'($urandom); b.stim = 8'($urandom);
        b.slot = 7'($urandom); b.tid = 8'($urandom); b.pos = 10'($urandom);
        return b;
    endfunction

    task automatic send_read();
        t_beat b;
        int a;
        if (written_addrs.size() == 0) return;
        b = rand_beat(slec_pkg::ACT_READ);
        a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        b.slot = 7'(a / ENTRIES); b.pos = 10'(a % ENTRIES);
        send_beat(b);
    endtask

    task automatic send_sample(int stim, logic [23:0] value);
        t_beat b;
        b = rand_beat(slec_pkg::ACT_SAMPLE);
        b.stim = 8'(stim); b.sample = value;
        send_beat(b);
    endtask

    // stimulus code biased toward codes that label as target
    function automatic int pick_stim();
        int cur, t, rows;
        cur = cur_tgt < clampi(reg_tc, 1, 16) ? cur_tgt : clampi(reg_tc, 1, 16) - 1;
        t = tgt_table[cur];
        rows = reg_rows ? reg_rows : 1;
        case ($urandom_range(0, 3))
            0: return reg_rc ? row_of(t, rows) : t;
            1: return reg_rc ? col_of(t, rows) : t;
            2: return $urandom_range(1, 2 * rows + 1);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    task automatic drain_results();
        @(negedge i_clk);
        push = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic cfg_write(slec_pkg::t_reg_idx idx, int data);
        @(negedge i_clk);
        i_cfg_we = 1; i_cfg_idx = idx; i_cfg_data = 8'(data);
        @(posedge i_clk);
        case (idx)
            slec_pkg::REG_CHANNEL_COUNT:     reg_cc   = data & 8'h0F;
            slec_pkg::REG_WINDOW_LENGTH:     reg_wl   = data & 8'hFF;
            slec_pkg::REG_EPOCHS_PER_TARGET: reg_ept  = data & 8'hFF;
            slec_pkg::REG_TARGET_COUNT:      reg_tc   = data & 8'h1F;
            slec_pkg::REG_ROW_COL_MODE:      reg_rc   = data & 8'h01;
            slec_pkg::REG_GRID_ROWS:         reg_rows = data & 8'h1F;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic set_config(int cc, int wl, int ept, int tc, int rc, int rows);
        drain_results();
        cfg_write(slec_pkg::REG_CHANNEL_COUNT, cc);
        cfg_write(slec_pkg::REG_WINDOW_LENGTH, wl);
        cfg_write(slec_pkg::REG_EPOCHS_PER_TARGET, ept);
        cfg_write(slec_pkg::REG_TARGET_COUNT, tc);
        cfg_write(slec_pkg::REG_ROW_COL_MODE, rc);
        cfg_write(slec_pkg::REG_GRID_ROWS, rows);
    endtask

    // ---------------- tests ----------------
    task automatic test_load_targets();
        t_beat b;
        for (int i = 0; i < TARGETS; i++) begin
            b = rand_beat(slec_pkg::ACT_LOAD);
            b.slot = 7'(i);
            b.tid = (i == 0) ? 8'd255 : (i == 1) ? 8'd0 : 8'($urandom_range(1, 40));
            send_beat(b);
        end
        b = rand_beat(slec_pkg::ACT_LOAD);
        b.slot = 7'd127;   // past the target table: ignored
        send_beat(b);
    endtask

    task automatic test_directed_edges();
        t_beat b;
        set_config(2, 1, 1, 2, 0, 6);
        send_beat(rand_beat(slec_pkg::ACT_NEW));
        // target epoch then non-target epoch, extreme sample values
        send_sample(255, 24'h7FFFFF);
        send_sample(5, 24'h800000);      // code off channel 0 is ignored
        send_sample(9, 24'h000000);
        send_sample(0, 24'hFFFFFF);
        // both slots used: stimulus rejected, last target repeats done
        send_sample(1, 24'h123456);
        send_sample(0, 24'h654321);
        b = rand_beat(slec_pkg::ACT_READ); b.slot = 0; b.pos = 0; send_beat(b);
        b = rand_beat(slec_pkg::ACT_READ); b.slot = 1; b.pos = 1; send_beat(b);
    endtask

    task automatic test_random_phase(int nbeats);
        int pick, rows;
        t_beat b;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            set_config(8, $urandom_range(0, 1) ? 128 : 255, 128, 16, $urandom_range(0, 1), 16);
        else if (pick == 1)
            set_config($urandom_range(0, 1) ? 0 : 15, 0, $urandom_range(0, 1) ? 0 : 255,
                       $urandom_range(0, 1) ? 0 : 31, 1, $urandom_range(0, 1) ? 0 : 31);
        else if (pick == 2)
            set_config(1, 128, $urandom_range(1, 2), 1, 0, 6);
        else begin
            rows = $urandom_range(1, 16);
            set_config($urandom_range(1, 8), $urandom_range(1, 5), $urandom_range(1, 4),
                       $urandom_range(1, 5), $urandom_range(0, 1), rows);
        end
        if ($urandom_range(0, 3) != 0) send_beat(rand_beat(slec_pkg::ACT_NEW));
        for (int k = 0; k < nbeats; k++) begin
            case ($urandom_range(0, 24))
                0, 1: send_read();
                2: begin
                    b = rand_beat(slec_pkg::ACT_LOAD);
                    if ($urandom_range(0, 3) != 0) b.slot = 7'($urandom_range(0, 15));
                    send_beat(b);
                end
                3: if ($urandom_range(0, 3) == 0) send_beat(rand_beat(slec_pkg::ACT_NEW));
                default: begin
                    if (chan == 0 && $urandom_range(0, 1))
                        send_sample(pick_stim(), 24'($urandom));
                    else if ($urandom_range(0, 9) == 0)
                        send_sample($urandom_range(1, 255), 24'($urandom));
                    else
                        send_sample(0, 24'($urandom));
                end
            endcase
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        drain_results();
        hold_req = 1;
        for (int k = 0; k < 40; k++) send_sample(0, 24'($urandom));
    endtask

    // ---------------- receiver side ----------------
    initial forever begin
        @(negedge i_clk);
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = 1200;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            pop = 0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            hold_cnt = $urandom_range(1, 13) - 1;
            pop = 0;
        end else begin
            pop = 1;
        end
    end

    function automatic void compare_field(string name, int unsigned exp_v, logic [23:0] act_v);
        if (act_v !== exp_v[23:0]) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        slec_pkg::t_result e;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat", $time);
                errors++;
            end else begin
                e = pending_results.pop_front();
                compare_field("target_done", e.target_done, o_target_done);
                compare_field("session_done", e.session_done, o_session_done);
                compare_field("read_sample", e.read_sample, o_read_sample);
                compare_field("read_stimulus", e.read_stimulus, o_read_stimulus);
                compare_field("read_label", e.read_label, o_read_label);
                compare_field("error", e.error, o_error);
            end
        end
    end

    // watchdog: cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog: no progress", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SLOTS * ENTRIES; i++) mem_written[i] = 0;
        for (int i = 0; i < TARGETS; i++) tgt_table[i] = 0;
        clear_session();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        test_load_targets();
        test_directed_edges();
        test_backpressure();
        while (beats_sent < 1500) test_random_phase($urandom_range(60, 120));
        quiet = 1;
        while (beats_sent < 1700) test_random_phase(60);

        drain_results();
        repeat (200) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
src/slec_pkg.sv
src/slec_fifo.sv
src/slec_front.sv
src/slec_div.sv
src/slec_back.sv
src/stimulus_locked_epoch_capture.sv
test/stimulus_locked_epoch_capture_tb.sv
